@@ src/per_service_snapshot_rate_gate_defines.svh @@
// Assertion macros for the snapshot rate gate.
// Used by the top level; expects clk and arst_n in scope.
`ifndef PER_SERVICE_SNAPSHOT_RATE_GATE_DEFINES_SVH
`define PER_SERVICE_SNAPSHOT_RATE_GATE_DEFINES_SVH
`ifndef SYNTHESIS
`define PSG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PSG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PSG_ASSERT_IMP(lbl, ante, cons, msg)
`define PSG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/psg_pkg.sv @@
// Shared constants, types and the tier table of the snapshot rate gate.
// No dependencies.
`default_nettype none
package psg_pkg;
	localparam int NUM_SERVICES = 20;
	localparam int MAX_STAGED   = 32;
	localparam int SVC_IW       = 5;
	localparam int STG_IW       = 5;
	localparam int CNT_W        = 6;
	localparam int DIGIT_W      = 4;
	localparam int NUM_DIGITS   = 16;

	localparam logic [1:0] CMD_OFFER  = 2'd0;
	localparam logic [1:0] CMD_COMMIT = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] REG_FAST = 2'd0;
	localparam logic [1:0] REG_SLOW = 2'd1;

	typedef enum logic [1:0] {
		TIER_EXCLUDED = 2'd0,
		TIER_FAST     = 2'd1,
		TIER_SLOW     = 2'd2
	} tier_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] now;
		logic [DIGIT_W-1:0] upd;
		logic [DIGIT_W-1:0] seen;
		logic [DIGIT_W-1:0] wall;
		logic [DIGIT_W-1:0] ivl;
	} digit_t;

	typedef struct packed {
		logic        newer;
		logic        early;
		logic [31:0] age;
	} dres_t;

	function automatic tier_t tier_of(input logic [7:0] svc);
		tier_t t;
		t = TIER_EXCLUDED;
		if (svc < 8'(NUM_SERVICES)) begin
			unique case (svc[SVC_IW-1:0])
				5'd4: t = TIER_EXCLUDED;
				5'd10, 5'd12, 5'd14, 5'd15, 5'd16, 5'd17, 5'd19: t = TIER_SLOW;
				default: t = TIER_FAST;
			endcase
		end
		return t;
	endfunction
endpackage
`default_nettype wire

@@ src/psg_digit_unit.sv @@
// Digit-serial compare and subtract unit: one 4-bit digit per cycle while step is high, LSB first.
// Depends on psg_pkg.
`default_nettype none
module psg_digit_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           step,
	input  wire logic [3:0]     digit_idx,
	input  psg_pkg::digit_t     d,
	output psg_pkg::dres_t      res
);
	import psg_pkg::*;

	logic b1_q, b2_q, b3_q, b4_q, wnz_q, hnz_q;
	logic [31:0] age_q;
	logic [DIGIT_W:0] t1, t2, t3, t4;

	always_comb begin
		t1 = {1'b0, d.seen} - {1'b0, d.upd} - {{DIGIT_W{1'b0}}, b1_q};
		t2 = {1'b0, d.now} - {1'b0, d.wall} - {{DIGIT_W{1'b0}}, b2_q};
		t3 = {1'b0, t2[DIGIT_W-1:0]} - {1'b0, d.ivl} - {{DIGIT_W{1'b0}}, b3_q};
		t4 = {1'b0, d.now} - {1'b0, d.upd} - {{DIGIT_W{1'b0}}, b4_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_q  <= 1'b0;
			b2_q  <= 1'b0;
			b3_q  <= 1'b0;
			b4_q  <= 1'b0;
			wnz_q <= 1'b0;
			hnz_q <= 1'b0;
		end else if (start) begin
			b1_q  <= 1'b0;
			b2_q  <= 1'b0;
			b3_q  <= 1'b0;
			b4_q  <= 1'b0;
			wnz_q <= 1'b0;
			hnz_q <= 1'b0;
		end else if (step) begin
			b1_q  <= t1[DIGIT_W];
			b2_q  <= t2[DIGIT_W];
			b3_q  <= t3[DIGIT_W];
			b4_q  <= t4[DIGIT_W];
			wnz_q <= wnz_q | (|d.wall);
			// upper half of the age only matters for saturation
			if (digit_idx[3]) hnz_q <= hnz_q | (|t4[DIGIT_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (step && !digit_idx[3]) age_q <= {t4[DIGIT_W-1:0], age_q[31:DIGIT_W]};
	end

	always_comb begin
		res.newer = b1_q;
		res.early = wnz_q & (b2_q | b3_q);
		if (b4_q)       res.age = '0;
		else if (hnz_q) res.age = '1;
		else            res.age = age_q;
	end
endmodule
`default_nettype wire

@@ src/per_service_snapshot_rate_gate.sv @@
// Top level of the snapshot rate gate: handshakes, control sequencer, tables.
// Depends on psg_pkg, psg_digit_unit and per_service_snapshot_rate_gate_defines.svh.
//
// Input channel s_*: one item per command (offer, commit, clear). tuser holds
// command[1:0] and batch_first[2]; tdata holds service, update time, now and
// payload length. Every item gives exactly one result on m_*.
// Offers run the 64-bit time checks in 4-bit digits through one serial unit,
// then a decision state and the wait for the output register.
// A commit walks the staged entries one per cycle, then clears the staging count.
// Clear and unused commands go straight from acceptance to the result state.
// One item is in work at a time; a new item is taken while the previous
// result still sits in the output register. If the receiver stalls, the next
// finished result waits in the sequencer until the output register frees.
// Reset clears the per-service tables, staging count, batch time and loads
// the interval registers with 50 and 1000 ms. Config writes are always ready.
`default_nettype none
`include "per_service_snapshot_rate_gate_defines.svh"
module per_service_snapshot_rate_gate (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [167:0] s_tdata,   // service, update_time_ms, now_ms, payload_bytes
	input  wire logic [2:0]   s_tuser,   // command, batch_first
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [79:0]       m_tdata,   // age_ms, service_out, payload_len_out, staged_count, pad
	output logic [1:0]        m_tuser,   // included, stage_full
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);
	import psg_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CALC   = 5'b00010,
		ST_EVAL   = 5'b00100,
		ST_COMMIT = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q;
	logic [15:0] fast_q, slow_q;
	logic [63:0] lus_q [NUM_SERVICES];
	logic [63:0] liw_q [NUM_SERVICES];
	logic [SVC_IW-1:0] stg_svc_q [MAX_STAGED];
	logic [63:0]       stg_upd_q [MAX_STAGED];
	logic [CNT_W-1:0] entries_q, k_q;
	logic [63:0] batch_wall_q;
	logic [63:0] now_sh_q, upd_sh_q, seen_sh_q, wall_sh_q, ivl_sh_q;
	logic [3:0] cnt_q;
	logic [7:0] svc_q;
	logic [31:0] len_q;
	logic elig_q, ivl_nz_q;
	logic r_incl_q, r_full_q;
	logic [31:0] r_age_q;
	logic [CNT_W-1:0] r_cnt_q;
	logic m_tvalid_q, o_incl_q, o_full_q;
	logic [31:0] o_age_q, o_len_q;
	logic [7:0] o_svc_q;
	logic [CNT_W-1:0] o_cnt_q;

	logic s_acc;
	logic [1:0] in_cmd;
	logic in_first;
	logic [7:0] in_svc;
	logic [63:0] in_upd, in_now;
	logic [31:0] in_len;
	tier_t in_tier;
	logic [SVC_IW-1:0] in_idx;
	digit_t dig;
	dres_t dres;
	logic due;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;
	assign in_cmd    = s_tuser[1:0];
	assign in_first  = s_tuser[2];
	assign in_svc    = s_tdata[7:0];
	assign in_upd    = s_tdata[71:8];
	assign in_now    = s_tdata[135:72];
	assign in_len    = s_tdata[167:136];
	assign in_tier   = tier_of(in_svc);
	assign in_idx    = (in_svc < 8'(NUM_SERVICES)) ? in_svc[SVC_IW-1:0] : '0;

	assign dig.now  = now_sh_q[DIGIT_W-1:0];
	assign dig.upd  = upd_sh_q[DIGIT_W-1:0];
	assign dig.seen = seen_sh_q[DIGIT_W-1:0];
	assign dig.wall = wall_sh_q[DIGIT_W-1:0];
	assign dig.ivl  = ivl_sh_q[DIGIT_W-1:0];

	psg_digit_unit u_digit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_acc),
		.step      (state_q == ST_CALC),
		.digit_idx (cnt_q),
		.d         (dig),
		.res       (dres)
	);

	assign due = elig_q & dres.newer & ~(ivl_nz_q & dres.early);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q <= 16'd50;
			slow_q <= 16'd1000;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_FAST) fast_q <= cfg_data;
			if (cfg_index == REG_SLOW) slow_q <= cfg_data;
		end
	end

	// control and per-service tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			entries_q    <= '0;
			k_q          <= '0;
			cnt_q        <= '0;
			batch_wall_q <= '0;
			for (int i = 0; i < NUM_SERVICES; i++) begin
				lus_q[i] <= '0;
				liw_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						cnt_q <= '0;
						k_q   <= '0;
						unique case (in_cmd)
							CMD_OFFER: begin
								if (in_first) begin
									entries_q    <= '0;
									batch_wall_q <= in_now;
								end
								state_q <= ST_CALC;
							end
							CMD_COMMIT: state_q <= ST_COMMIT;
							CMD_CLEAR: begin
								entries_q <= '0;
								for (int i = 0; i < NUM_SERVICES; i++) begin
									lus_q[i] <= '0;
									liw_q[i] <= '0;
								end
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_CALC: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(NUM_DIGITS - 1)) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (due && entries_q < CNT_W'(MAX_STAGED)) entries_q <= entries_q + 1'b1;
					state_q <= ST_DONE;
				end
				ST_COMMIT: begin
					if (k_q < entries_q) begin
						if (stg_svc_q[k_q[STG_IW-1:0]] < SVC_IW'(NUM_SERVICES)) begin
							lus_q[stg_svc_q[k_q[STG_IW-1:0]]] <= stg_upd_q[k_q[STG_IW-1:0]];
							liw_q[stg_svc_q[k_q[STG_IW-1:0]]] <= batch_wall_q;
						end
						k_q <= k_q + 1'b1;
					end else begin
						entries_q <= '0;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand shift registers, staging and pending result
	always_ff @(posedge clk) begin
		if (s_acc) begin
			svc_q     <= (in_cmd == CMD_OFFER) ? in_svc : '0;
			len_q     <= (in_cmd == CMD_OFFER) ? in_len : '0;
			elig_q    <= (in_len != '0) && (in_tier != TIER_EXCLUDED);
			now_sh_q  <= in_now;
			upd_sh_q  <= in_upd;
			seen_sh_q <= lus_q[in_idx];
			wall_sh_q <= liw_q[in_idx];
			ivl_sh_q  <= {48'd0, (in_tier == TIER_SLOW) ? slow_q : fast_q};
			ivl_nz_q  <= ((in_tier == TIER_SLOW) ? slow_q : fast_q) != '0;
			r_incl_q  <= 1'b0;
			r_full_q  <= 1'b0;
			r_age_q   <= '0;
			r_cnt_q   <= '0;
		end else if (state_q == ST_CALC) begin
			// rotate so update time is whole again after the last digit
			now_sh_q  <= {now_sh_q[DIGIT_W-1:0], now_sh_q[63:DIGIT_W]};
			upd_sh_q  <= {upd_sh_q[DIGIT_W-1:0], upd_sh_q[63:DIGIT_W]};
			seen_sh_q <= {seen_sh_q[DIGIT_W-1:0], seen_sh_q[63:DIGIT_W]};
			wall_sh_q <= {wall_sh_q[DIGIT_W-1:0], wall_sh_q[63:DIGIT_W]};
			ivl_sh_q  <= {ivl_sh_q[DIGIT_W-1:0], ivl_sh_q[63:DIGIT_W]};
		end else if (state_q == ST_EVAL) begin
			r_cnt_q <= entries_q;
			if (due) begin
				if (entries_q >= CNT_W'(MAX_STAGED)) begin
					r_full_q <= 1'b1;
				end else begin
					stg_svc_q[entries_q[STG_IW-1:0]] <= svc_q[SVC_IW-1:0];
					stg_upd_q[entries_q[STG_IW-1:0]] <= upd_sh_q;
					r_incl_q <= 1'b1;
					r_age_q  <= dres.age;
					r_cnt_q  <= entries_q + 1'b1;
				end
			end
		end else if (state_q == ST_COMMIT) begin
			r_cnt_q <= entries_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			o_incl_q <= r_incl_q;
			o_full_q <= r_full_q;
			o_age_q  <= r_age_q;
			o_svc_q  <= svc_q;
			o_len_q  <= len_q;
			o_cnt_q  <= r_cnt_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, o_cnt_q, o_len_q, o_svc_q, o_age_q};
	assign m_tuser  = {o_full_q, o_incl_q};

	`PSG_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
	`PSG_ASSERT_IMP(a_incl_full, m_tvalid, !(m_tuser[0] && m_tuser[1]), "included and full")
	`PSG_ASSERT_IMP(a_entries, 1'b1, entries_q <= CNT_W'(MAX_STAGED), "staging overflow")
	`PSG_ASSERT_IMP(a_idle_out, state_q == ST_CALC, !s_tready, "ready during digit work")
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for per_service_snapshot_rate_gate: directed offers, commits and
// clears, then random batches, with an in-bench gate predictor checked against every result.
// Depends on psg_pkg and the RTL of the block.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import psg_pkg::*;

	typedef struct {
		logic [1:0]  cmd;
		logic        first;
		logic [7:0]  svc;
		logic [63:0] upd;
		logic [63:0] now;
		logic [31:0] len;
	} offer_t;

	typedef struct {
		logic        inc;
		logic [31:0] age;
		logic [7:0]  svc;
		logic [31:0] len;
		logic [5:0]  cnt;
		logic        full;
	} verdict_t;

	localparam int    WATCHDOG_LIMIT = 20000;
	localparam [1:0]  CMD_UNUSED     = 2'd3;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [167:0] s_tdata = '0;   // service, update_time_ms, now_ms, payload_bytes
	logic [2:0]   s_tuser = '0;   // command, batch_first
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [79:0]  m_tdata;        // age_ms, service_out, payload_len_out, staged_count, pad
	logic [1:0]   m_tuser;        // included, stage_full
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;

	per_service_snapshot_rate_gate dut (.*);

	always #5 clk = ~clk;

	// gate model state
	logic [15:0] fast_ivl = 16'd50, slow_ivl = 16'd1000;
	logic [63:0] seen_upd [NUM_SERVICES];
	logic [63:0] incl_wall [NUM_SERVICES];
	logic [7:0]  stg_svc [MAX_STAGED];
	logic [63:0] stg_upd [MAX_STAGED];
	int unsigned stg_n;
	logic [63:0] batch_wall;

	offer_t   offer_q[$];
	offer_t   cur_offer;
	verdict_t verdict_q[$];
	int       errors = 0;
	int       send_idle = 0, recv_idle = 0;
	logic [63:0] tbase = 64'd5000;

	function automatic tier_t svc_tier(input logic [7:0] s);
		if (s >= 8'(NUM_SERVICES)) return TIER_EXCLUDED;
		case (s)
			8'd4: return TIER_EXCLUDED;
			8'd10, 8'd12, 8'd14, 8'd15, 8'd16, 8'd17, 8'd19: return TIER_SLOW;
			default: return TIER_FAST;
		endcase
	endfunction

	function automatic verdict_t gate_verdict(input offer_t o);
		verdict_t v;
		tier_t t;
		logic [63:0] ivl, a;
		logic due;
		v = '{default: '0};
		if (o.cmd == CMD_OFFER) begin
			v.svc = o.svc;
			v.len = o.len;
			if (o.first) begin
				stg_n = 0;
				batch_wall = o.now;
			end
			t = svc_tier(o.svc);
			if (o.len != 0 && t != TIER_EXCLUDED) begin
				ivl = (t == TIER_SLOW) ? 64'(slow_ivl) : 64'(fast_ivl);
				due = o.upd > seen_upd[o.svc];
				if (due && ivl != 0 && incl_wall[o.svc] != 0 &&
				    (o.now < incl_wall[o.svc] || o.now - incl_wall[o.svc] < ivl))
					due = 1'b0;
				if (due) begin
					if (stg_n >= MAX_STAGED) begin
						v.full = 1'b1;
					end else begin
						a = (o.now > o.upd) ? o.now - o.upd : 64'd0;
						stg_svc[stg_n] = o.svc;
						stg_upd[stg_n] = o.upd;
						stg_n++;
						v.inc = 1'b1;
						v.age = (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
					end
				end
			end
			v.cnt = 6'(stg_n);
		end else if (o.cmd == CMD_COMMIT) begin
			for (int k = 0; k < stg_n; k++) begin
				seen_upd[stg_svc[k]] = stg_upd[k];
				incl_wall[stg_svc[k]] = batch_wall;
			end
			v.cnt = 6'(stg_n);
			stg_n = 0;
		end else if (o.cmd == CMD_CLEAR) begin
			for (int k = 0; k < NUM_SERVICES; k++) begin
				seen_upd[k] = '0;
				incl_wall[k] = '0;
			end
			stg_n = 0;
		end
		return v;
	endfunction

	task automatic push(input logic [1:0] c, input logic f, input logic [7:0] s,
	                    input logic [63:0] u, input logic [63:0] n, input logic [31:0] l);
		offer_t o;
		o = '{cmd: c, first: f, svc: s, upd: u, now: n, len: l};
		offer_q.insert(offer_q.size(), o);
	endtask

	task automatic compare(input string name, input logic [63:0] exp, input logic [63:0] act);
		if (exp !== act) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			errors++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) verdict_q.insert(verdict_q.size(), gate_verdict(cur_offer));
			if (!s_tvalid || s_tready) begin
				if (offer_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					cur_offer = offer_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {cur_offer.len, cur_offer.now, cur_offer.upd, cur_offer.svc};
					s_tuser <= {cur_offer.first, cur_offer.cmd};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		verdict_t v;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					$error("result with no pending expectation");
					errors++;
				end else begin
					v = verdict_q.pop_front();
					compare("included", 64'(v.inc), 64'(m_tuser[0]));
					compare("stage_full", 64'(v.full), 64'(m_tuser[1]));
					compare("age_ms", 64'(v.age), 64'(m_tdata[31:0]));
					compare("service_out", 64'(v.svc), 64'(m_tdata[39:32]));
					compare("payload_len_out", 64'(v.len), 64'(m_tdata[71:40]));
					compare("staged_count", 64'(v.cnt), 64'(m_tdata[77:72]));
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// watchdog: cycles with work pending but no handshake
	int stall_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
			    (offer_q.size() == 0 && !s_tvalid && verdict_q.size() == 0 && !cfg_valid))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_FAST) fast_ivl = val;
		else slow_ivl = val;
	endtask

	task automatic drain;
		while (offer_q.size() > 0 || s_tvalid || verdict_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic random_items(input int target);
		int n, r, k;
		logic [7:0] s;
		logic [63:0] u;
		logic [31:0] l;
		n = 0;
		while (n < target) begin
			r = $urandom_range(99);
			if (r < 70) begin
				// well-formed batch, sometimes long enough to overflow staging
				k = ($urandom_range(14) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 12);
				if ($urandom_range(19) == 0) tbase = {$urandom, $urandom};
				else tbase += (k > 30) ? $urandom_range(2000, 70000) : $urandom_range(0, 1500);
				for (int j = 0; j < k; j++) begin
					s = (k > 30) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 21));
					case ($urandom_range(9))
						0: u = tbase + $urandom_range(1, 500);
						1: u = {$urandom, $urandom};
						default: u = tbase - $urandom_range(0, 400);
					endcase
					if (k > 30) u = tbase + j + 1;
					l = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom);
					push(CMD_OFFER, j == 0, s, u, tbase, l);
				end
				n += k;
				if ($urandom_range(99) < 85) begin
					push(CMD_COMMIT, 1'($urandom_range(1)), 8'($urandom), {$urandom, $urandom},
					     {$urandom, $urandom}, $urandom);
					n++;
				end
			end else if (r < 82) begin
				push(CMD_OFFER, 1'($urandom_range(1)), 8'($urandom), {$urandom, $urandom},
				     {$urandom, $urandom}, $urandom);
				n++;
			end else if (r < 90) begin
				push(CMD_COMMIT, 1'b0, '0, '0, '0, '0);
				n++;
			end else if (r < 94) begin
				push(CMD_CLEAR, 1'($urandom_range(1)), 8'($urandom), {$urandom, $urandom},
				     {$urandom, $urandom}, $urandom);
				n++;
			end else begin
				push(CMD_UNUSED, 1'($urandom_range(1)), 8'($urandom), {$urandom, $urandom},
				     {$urandom, $urandom}, $urandom);
				n++;
			end
		end
	endtask

	initial begin
		for (int k = 0; k < NUM_SERVICES; k++) begin
			seen_upd[k] = '0;
			incl_wall[k] = '0;
		end
		stg_n = 0;
		batch_wall = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset intervals
		push(CMD_OFFER, 1'b1, 8'd0, 64'd5, 64'd100, 32'd1);
		push(CMD_OFFER, 1'b0, 8'd4, 64'd5, 64'd100, 32'd7);
		push(CMD_OFFER, 1'b0, 8'd19, 64'd50, 64'd100, 32'd9);
		push(CMD_OFFER, 1'b0, 8'd20, 64'd5, 64'd100, 32'd9);
		push(CMD_OFFER, 1'b0, 8'd255, '1, '1, '1);
		push(CMD_OFFER, 1'b0, 8'd1, 64'd5, 64'd100, 32'd0);
		push(CMD_OFFER, 1'b0, 8'd1, 64'd500, 64'd100, 32'd3);
		push(CMD_OFFER, 1'b0, 8'd2, 64'd0, 64'd100, 32'd3);
		push(CMD_OFFER, 1'b0, 8'd3, 64'd1, '1, 32'd3);
		push(CMD_OFFER, 1'b0, 8'd0, 64'd6, 64'd100, 32'd2);
		push(CMD_COMMIT, 1'b0, '0, '0, '0, '0);
		push(CMD_OFFER, 1'b1, 8'd0, 64'd200, 64'd120, 32'd4);
		push(CMD_OFFER, 1'b0, 8'd0, 64'd200, 64'd50, 32'd4);
		push(CMD_OFFER, 1'b0, 8'd0, 64'd6, 64'd150, 32'd4);
		push(CMD_OFFER, 1'b1, 8'd0, 64'd300, 64'd150, 32'd4);
		push(CMD_OFFER, 1'b0, 8'd19, 64'd60, 64'd1099, 32'd4);
		push(CMD_OFFER, 1'b0, 8'd19, 64'd60, 64'd1100, 32'd4);
		push(CMD_UNUSED, 1'b1, 8'hFF, '1, '1, '1);
		push(CMD_COMMIT, 1'b1, 8'hFF, '1, '1, '1);
		push(CMD_COMMIT, 1'b0, '0, '0, '0, '0);
		push(CMD_CLEAR, 1'b0, '0, '0, '0, '0);
		push(CMD_OFFER, 1'b1, 8'd0, 64'd1, 64'd160, 32'd4);
		drain();

		write_reg(REG_FAST, 16'd0);
		write_reg(REG_SLOW, 16'hFFFF);
		send_idle = 35;
		recv_idle = 72;
		random_items(440);
		drain();

		write_reg(REG_FAST, 16'hFFFF);
		write_reg(REG_SLOW, 16'd0);
		send_idle = 72;
		recv_idle = 35;
		random_items(440);
		drain();

		write_reg(REG_FAST, 16'($urandom_range(1, 400)));
		write_reg(REG_SLOW, 16'($urandom_range(1, 3000)));
		send_idle = 0;
		recv_idle = 0;
		random_items(450);
		drain();

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
